### hdl/assert_macros.svh
// Assertion macros shared by the effect engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/lsee_pkg.sv
// Types and constants shared by the LED segment effect engine modules.
package lsee_pkg;

  localparam int COL_W      = 8;
  localparam int BRT_W      = 9;
  localparam int TIME_W     = 16;
  localparam int POS_W      = 12;
  localparam int SPAN_W     = 9;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int PROD_W     = 25;
  localparam int DIVN_W     = 24;
  localparam int DIVD_W     = 16;
  localparam int DIV_STEPS  = DIVN_W;
  localparam int DCNT_W     = 5;
  localparam int MAX_WRITES = 64;

  localparam logic [BRT_W-1:0]  BRT_RESET       = 9'd230;
  localparam logic [DIVD_W-1:0] STROBE_PERIOD   = 16'd6;
  localparam logic [DIVD_W-1:0] STROBE_DARK_MAX = 16'd2;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_FADE   = 2'd1;
  localparam logic [1:0] OP_STROBE = 2'd2;
  localparam logic [1:0] OP_CHASE  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] clock_now;
    logic [5:0]        seg_start;
    logic [6:0]        seg_length;
    logic [TIME_W-1:0] win_start;
    logic [TIME_W-1:0] win_length;
    logic [TIME_W-1:0] repeat_period;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic              chase_backward;
    logic [6:0]        chase_width;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quot;
    logic [DIVD_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] lo;
    logic [CNT_W-1:0] n;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } emit_job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_WRAP_W,
    S_WIN,
    S_MOD6,
    S_FMUL,
    S_FDIV,
    S_FDIV_W,
    S_CMUL,
    S_CDIV,
    S_CDIV_W,
    S_SCALE,
    S_SCALE_W,
    S_RANGE,
    S_HAND
  } seq_state_t;

endpackage

### hdl/led_segment_effect_engine_core.sv
// Top level of the LED segment effect engine: stream ports, brightness register, units.
// Flow: the wrap modulo and each of the three fade divides hold the sequencer on the shared
//   divider; the next command is taken once the sequencer is idle again (later while the emitter
//   still drains a run); the emitter sends one word per cycle while the sink is ready, up to 64
//   per command.
// Reset: rst is synchronous, active high; it idles all units and sets brightness to 230.
module led_segment_effect_engine_core #(
  parameter int STRIP_LEDS = 64
) (
  input  logic         clk,
  input  logic         rst,
  // Command stream in.
  input  logic         s_tvalid,
  output logic         s_tready,
  // clock_now[15:0], seg_start[21:16], seg_length[28:22], win_start[44:29],
  // win_length[60:45], repeat_period[76:61], red[84:77], green[92:85],
  // blue[100:93], chase_backward[101], chase_width[108:102], zero pad above
  input  logic [111:0] s_tdata,
  // op[1:0]
  input  logic [1:0]   s_tuser,
  // Pixel write stream out.
  output logic         m_tvalid,
  input  logic         m_tready,
  // led_index[5:0], out_red[13:6], out_green[21:14], out_blue[29:22], zero pad above
  output logic [31:0]  m_tdata,
  output logic         m_tlast,
  // write_valid[0]
  output logic         m_tuser,
  // Brightness register write.
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata
);
  import lsee_pkg::*;

  logic [BRT_W-1:0] brightness_q8;
  cmd_t             cmd;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  emit_job_t        job;
  logic             emit_idle;

  // Brightness multiplier, Q1.8; scaled results above 255 saturate in the scaler.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_q8 <= BRT_RESET;
    end else if (cfg_we) begin
      brightness_q8 <= cfg_wdata;
    end
  end

  // Unpack the command word.
  assign cmd.op             = s_tuser;
  assign cmd.clock_now      = s_tdata[15:0];
  assign cmd.seg_start      = s_tdata[21:16];
  assign cmd.seg_length     = s_tdata[28:22];
  assign cmd.win_start      = s_tdata[44:29];
  assign cmd.win_length     = s_tdata[60:45];
  assign cmd.repeat_period  = s_tdata[76:61];
  assign cmd.red            = s_tdata[84:77];
  assign cmd.green          = s_tdata[92:85];
  assign cmd.blue           = s_tdata[100:93];
  assign cmd.chase_backward = s_tdata[101];
  assign cmd.chase_width    = s_tdata[108:102];

  // Shared divider: time wrap, fade ramp and chase step.
  lsee_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer: works out color and the clipped LED run for one command.
  lsee_seq #(
    .STRIP_LEDS (STRIP_LEDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_cmd     (cmd),
    .bright    (brightness_q8),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .job       (job),
    .emit_idle (emit_idle)
  );

  // Emitter: walk the run and hold each word until the sink takes it.
  lsee_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .idle     (emit_idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### hdl/lsee_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lsee_div (
  input  logic               clk,
  input  logic               rst,
  input  lsee_pkg::div_req_t req,
  output lsee_pkg::div_rsp_t rsp
);
  import lsee_pkg::*;

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [DIVN_W-1:0] quo;
  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] divisor;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W:0]   diff;
  logic              ge;

  assign shifted = {rem, quo[DIVN_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Shift one dividend bit into the partial remainder, subtract if it fits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIVN_W-2:0], ge};
      rem <= ge ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

### hdl/lsee_seq.sv
// Command sequencer: time wrap, window test, color math and write range.
module lsee_seq #(
  parameter int STRIP_LEDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  lsee_pkg::cmd_t                  s_cmd,
  input  logic [lsee_pkg::BRT_W-1:0]      bright,
  output lsee_pkg::div_req_t              div_req,
  input  lsee_pkg::div_rsp_t              div_rsp,
  output lsee_pkg::emit_job_t             job,
  input  logic                            emit_idle
);
  import lsee_pkg::*;

  localparam logic signed [POS_W-1:0] STRIP_POS = POS_W'(STRIP_LEDS);
  localparam logic signed [POS_W-1:0] MAX_POS   = POS_W'(MAX_WRITES);

  seq_state_t state, state_next;

  cmd_t                     cmd;
  logic [TIME_W-1:0]        t;
  logic [TIME_W-1:0]        d;
  logic [COL_W-1:0]         col [3];
  logic [1:0]               ch;
  logic [PROD_W-1:0]        prod;
  logic signed [SPAN_W-1:0] span;
  logic signed [POS_W-1:0]  first;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         lo;
  logic [CNT_W-1:0]         n;
  logic                     wrapped;

  logic                     need_wrap;
  logic                     active;
  logic [TIME_W-1:0]        mul_a;
  logic [BRT_W-1:0]         mul_b;
  logic signed [SPAN_W-1:0] span_c;
  logic [COL_W-1:0]         span_abs;
  logic signed [POS_W-1:0]  step_s;
  logic signed [POS_W-1:0]  chase_first;
  logic signed [POS_W-1:0]  hi_raw;
  logic signed [POS_W-1:0]  lo_c;
  logic signed [POS_W-1:0]  hi_c;
  logic signed [POS_W-1:0]  diff_c;
  logic [CNT_W-1:0]         n_c;
  logic [COL_W-1:0]         scaled;
  logic [4:0]               m3_sum;
  logic [2:0]               m3_fold;
  logic [1:0]               half_mod3;
  logic [2:0]               t_mod6;
  logic                     strobe_dark;

  assign need_wrap = (cmd.repeat_period != '0) && (cmd.repeat_period < t);
  assign active    = (t >= cmd.win_start) &&
                     ({1'b0, t} < ({1'b0, cmd.win_start} + {1'b0, cmd.win_length}));

  // t mod 6 = 2 * ((t >> 1) mod 3) + t[0]; base-4 digit sums keep the value mod 3.
  assign m3_sum      = 5'(t[2:1]) + 5'(t[4:3]) + 5'(t[6:5]) + 5'(t[8:7])
                     + 5'(t[10:9]) + 5'(t[12:11]) + 5'(t[14:13]) + 5'(t[15]);
  assign m3_fold     = 3'(m3_sum[1:0]) + 3'(m3_sum[3:2]) + 3'(m3_sum[4]);
  assign half_mod3   = (m3_fold >= 3'd6) ? 2'(m3_fold - 3'd6) :
                       (m3_fold >= 3'd3) ? 2'(m3_fold - 3'd3) : m3_fold[1:0];
  assign t_mod6      = {half_mod3, t[0]};
  assign strobe_dark = TIME_W'(t_mod6) <= STROBE_DARK_MAX;

  assign span_c   = $signed(SPAN_W'(cmd.seg_start) + SPAN_W'(cmd.seg_length)
                            - SPAN_W'(cmd.chase_width));
  assign span_abs = span[SPAN_W-1] ? COL_W'(-span) : span[COL_W-1:0];

  // Quotient magnitude is below |span|, so eight bits hold it.
  assign step_s      = span[SPAN_W-1] ? -$signed({4'b0, div_rsp.quot[COL_W-1:0]})
                                      :  $signed({4'b0, div_rsp.quot[COL_W-1:0]});
  assign chase_first = cmd.chase_backward
                     ? ($signed({{(POS_W-SPAN_W){span[SPAN_W-1]}}, span}) - step_s)
                     : step_s;

  assign hi_raw = first + $signed({{(POS_W-CNT_W){1'b0}}, count});
  assign lo_c   = first[POS_W-1] ? '0 : first;
  assign hi_c   = (hi_raw > STRIP_POS) ? STRIP_POS : hi_raw;
  assign diff_c = hi_c - lo_c;
  assign n_c    = (diff_c <= 0) ? '0 :
                  (diff_c >= MAX_POS) ? CNT_W'(MAX_WRITES) : diff_c[CNT_W-1:0];

  assign scaled = (prod[PROD_W-1:16] != '0) ? {COL_W{1'b1}} : prod[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    div_req          = '0;
    job              = '0;
    job.lo           = lo;
    job.n            = n;
    job.red          = col[0];
    job.green        = col[1];
    job.blue         = col[2];
    mul_a            = d;
    mul_b            = {1'b0, col[ch]};
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_WRAP;
      end
      S_WRAP: begin
        if (need_wrap) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVN_W'(t);
          div_req.divisor  = cmd.repeat_period;
          state_next       = S_WRAP_W;
        end else begin
          state_next = S_WIN;
        end
      end
      S_WRAP_W: begin
        if (div_rsp.done) state_next = S_WIN;
      end
      S_WIN: begin
        if (!active) begin
          state_next = S_HAND;
        end else begin
          unique case (cmd.op)
            OP_SET:    state_next = S_SCALE;
            OP_FADE:   state_next = S_FMUL;
            OP_STROBE: state_next = S_MOD6;
            OP_CHASE:  state_next = S_CMUL;
            default:   state_next = S_SCALE;
          endcase
        end
      end
      S_MOD6: begin
        state_next = S_SCALE;
      end
      S_FMUL: begin
        state_next = S_FDIV;
      end
      S_FDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIVN_W-1:0];
        div_req.divisor  = cmd.win_length;
        state_next       = S_FDIV_W;
      end
      S_FDIV_W: begin
        if (div_rsp.done) state_next = (ch == 2'd2) ? S_SCALE : S_FMUL;
      end
      S_CMUL: begin
        mul_b      = {1'b0, span_abs};
        state_next = S_CDIV;
      end
      S_CDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIVN_W-1:0];
        div_req.divisor  = cmd.win_length;
        state_next       = S_CDIV_W;
      end
      S_CDIV_W: begin
        if (div_rsp.done) state_next = S_SCALE;
      end
      S_SCALE: begin
        mul_a      = TIME_W'(col[ch]);
        mul_b      = bright;
        state_next = S_SCALE_W;
      end
      S_SCALE_W: begin
        state_next = (ch == 2'd2) ? S_RANGE : S_SCALE;
      end
      S_RANGE: begin
        state_next = S_HAND;
      end
      S_HAND: begin
        if (emit_idle) begin
          job.start  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd <= s_cmd;
          t   <= s_cmd.clock_now;
        end
      end
      S_WRAP: begin
        wrapped <= need_wrap;
      end
      S_WRAP_W: begin
        if (div_rsp.done) t <= div_rsp.rem;
      end
      S_WIN: begin
        d      <= t - cmd.win_start;
        ch     <= '0;
        col[0] <= cmd.red;
        col[1] <= cmd.green;
        col[2] <= cmd.blue;
        span   <= span_c;
        first  <= POS_W'(cmd.seg_start);
        count  <= cmd.seg_length;
        lo     <= '0;
        n      <= '0;
      end
      S_MOD6: begin
        if (strobe_dark) begin
          col[0] <= '0;
          col[1] <= '0;
          col[2] <= '0;
        end
      end
      S_FMUL, S_CMUL, S_SCALE: begin
        prod <= {{BRT_W{1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};
      end
      S_FDIV_W: begin
        if (div_rsp.done) begin
          col[ch] <= col[ch] - div_rsp.quot[COL_W-1:0];
          ch      <= (ch == 2'd2) ? 2'd0 : ch + 2'd1;
        end
      end
      S_CDIV_W: begin
        if (div_rsp.done) begin
          first <= chase_first;
          count <= cmd.chase_width;
        end
      end
      S_SCALE_W: begin
        col[ch] <= scaled;
        ch      <= (ch == 2'd2) ? 2'd0 : ch + 2'd1;
      end
      S_RANGE: begin
        lo <= lo_c[IDX_W-1:0];
        n  <= n_c;
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_div_free, clk, rst, div_req.start, !div_rsp.busy)
  `ASSERT_NEXT(a_div_done_pulse, clk, rst, div_rsp.done, !div_rsp.done)
  `ASSERT_IMPL(a_wrap_below_period, clk, rst, state == S_WIN && wrapped, t < cmd.repeat_period)
  `ASSERT_IMPL(a_run_bounded, clk, rst, job.start, job.n <= CNT_W'(MAX_WRITES))

endmodule

### hdl/lsee_emit.sv
// Pixel write emitter with output register.
module lsee_emit (
  input  logic                clk,
  input  logic                rst,
  input  lsee_pkg::emit_job_t job,
  output logic                idle,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  import lsee_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] rem_ct;
  logic [COL_W-1:0] cr, cg, cb;
  logic             ov;
  logic [IDX_W-1:0] idx;
  logic [COL_W-1:0] r, g, b;
  logic             wv;
  logic             lastr;
  logic             load;

  assign load = !ov || m_tready;
  assign idle = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (job.start) busy <= 1'b1;
      if (busy && load) begin
        ov <= 1'b1;
        if (rem_ct <= CNT_W'(1)) busy <= 1'b0;
      end else if (m_tready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.start) begin
      pos    <= job.lo;
      rem_ct <= job.n;
      cr     <= job.red;
      cg     <= job.green;
      cb     <= job.blue;
    end else if (busy && load) begin
      if (rem_ct == '0) begin
        idx   <= '0;
        r     <= '0;
        g     <= '0;
        b     <= '0;
        wv    <= 1'b0;
        lastr <= 1'b1;
      end else begin
        idx    <= pos;
        r      <= cr;
        g      <= cg;
        b      <= cb;
        wv     <= 1'b1;
        lastr  <= (rem_ct == CNT_W'(1));
        pos    <= pos + 1'b1;
        rem_ct <= rem_ct - 1'b1;
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {2'b00, b, g, r, idx};
  assign m_tlast  = lastr;
  assign m_tuser  = wv;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_job_when_idle, clk, rst, job.start, !busy)
  `ASSERT_IMPL(a_empty_is_last, clk, rst, ov && !wv, lastr)
  `ASSERT_IMPL(a_empty_blank, clk, rst, ov && !wv, idx == '0 && r == '0 && g == '0 && b == '0)

endmodule
